### design/loc_pkg.sv
// ---------------------------------------------------------------------------
// loc_pkg: shared constants and types for the law of cosines block
// angle table, cordic start value, stage payload structs
// ---------------------------------------------------------------------------
package loc_pkg;

  localparam int CordicSteps = 16;
  localparam int TableLen    = 24;
  localparam int NumSteps    = (CordicSteps < TableLen) ? CordicSteps : TableLen;
  localparam int SqrtSteps   = 19;

  localparam logic [15:0] AngleMax   = 16'd46080;
  localparam logic [15:0] AngleRight = 16'd23040;
  localparam logic signed [33:0] CordicOne = 34'sd1073741824;
  localparam logic signed [33:0] CordicX0  = 34'sd652032874;

  typedef logic [22:0] atan_t;
  localparam atan_t AtanTab [TableLen] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833, 23'd917,
    23'd458, 23'd229, 23'd115, 23'd57, 23'd29, 23'd14, 23'd7, 23'd4, 23'd2,
    23'd1, 23'd0
  };

  // data carried by a cordic cell
  typedef struct packed {
    logic               vld;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [24:0] z;
    logic               neg;
    logic [15:0]        a;
    logic [15:0]        b;
  } cord_t;

  // data carried by a square root cell
  typedef struct packed {
    logic        vld;
    logic [37:0] rem;
    logic [37:0] root;
  } sq_t;

endpackage

### design/loc_cordic_cell.sv
// ---------------------------------------------------------------------------
// loc_cordic_cell: one rotation step of the cosine cordic
// shift amount and angle constant fixed by position in the row
// ---------------------------------------------------------------------------
module loc_cordic_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [4:0]          step,
  input  loc_pkg::cord_t      d_in,
  output loc_pkg::cord_t      d_out
);
  loc_pkg::cord_t q_r, q_nxt;
  logic signed [33:0] dx, dy;
  logic signed [24:0] at;

  always_comb begin
    dx = d_in.y >>> step;
    dy = d_in.x >>> step;
    at = signed'({2'b00, loc_pkg::AtanTab[step]});
    q_nxt = d_in;
    // synchronous reset clears the valid bit only
    q_nxt.vld = d_in.vld & rst_n;
    if (!d_in.z[24]) begin
      q_nxt.x = d_in.x - dx;
      q_nxt.y = d_in.y + dy;
      q_nxt.z = d_in.z - at;
    end else begin
      q_nxt.x = d_in.x + dx;
      q_nxt.y = d_in.y - dy;
      q_nxt.z = d_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign d_out = q_r;
endmodule

### design/loc_sqrt_cell.sv
// ---------------------------------------------------------------------------
// loc_sqrt_cell: one digit of the square root recurrence
// bit weight fixed by position in the row
// ---------------------------------------------------------------------------
module loc_sqrt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [5:0]     sh,
  input  loc_pkg::sq_t   d_in,
  output loc_pkg::sq_t   d_out
);
  loc_pkg::sq_t q_r, q_nxt;
  logic [37:0] bitv, trial;

  always_comb begin
    bitv  = 38'd1 << sh;
    trial = d_in.root + bitv;
    q_nxt = d_in;
    // synchronous reset clears the valid bit only
    q_nxt.vld = d_in.vld & rst_n;
    if (d_in.rem >= trial) begin
      q_nxt.rem  = d_in.rem - trial;
      q_nxt.root = (d_in.root >> 1) + bitv;
    end else begin
      q_nxt.root = d_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign d_out = q_r;
endmodule

### design/law_of_cosines_side.sv
// pipeline from start to out_valid: input register, cordic row, stages m1 to m3, root row, output register
// throughput: one item per cycle, busy is always low
// a row of cordic cells, a multiply section and a row of root digit cells set the depth
// rst_n (synchronous) clears the valid bits of every stage; no payload is reset
// the receiver cannot stall: each result shows on out_ for exactly one cycle
// ---------------------------------------------------------------------------
// law_of_cosines_side: opposite side of a triangle from two sides and angle
// c = sqrt(a^2 + b^2 - 2ab cos C) in fixed point, fully pipelined
// ---------------------------------------------------------------------------
module law_of_cosines_side (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_first_side,
  input  logic [15:0] in_second_side,
  input  logic [15:0] in_included_angle,
  output logic        out_valid,
  output logic [16:0] out_opposite_side
);
  localparam int N = loc_pkg::NumSteps;
  localparam int S = loc_pkg::SqrtSteps;

  logic        acc;
  logic [15:0] ang;
  logic [15:0] angf;
  loc_pkg::cord_t pre_r, pre_nxt;
  loc_pkg::cord_t crow [N+1];

  // no internal stall, so a new item can always enter
  assign busy = 1'b0;
  assign acc  = start & ~busy;

  // saturate above 180 degrees, fold above 90 degrees
  always_comb begin
    ang = (in_included_angle > loc_pkg::AngleMax) ? loc_pkg::AngleMax
                                                   : in_included_angle;
    pre_nxt.neg = ang > loc_pkg::AngleRight;
    angf = pre_nxt.neg ? (loc_pkg::AngleMax - ang) : ang;
    pre_nxt.vld = acc & rst_n;
    pre_nxt.x   = loc_pkg::CordicX0;
    pre_nxt.y   = '0;
    pre_nxt.z   = signed'({1'b0, angf, 8'd0});
    pre_nxt.a   = in_first_side;
    pre_nxt.b   = in_second_side;
  end

  always_ff @(posedge clk) begin
    pre_r <= pre_nxt;
  end

  assign crow[0] = pre_r;

  // cordic row
  for (genvar i = 0; i < N; i++) begin : g_cord
    loc_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (5'(i)),
      .d_in  (crow[i]),
      .d_out (crow[i+1])
    );
  end

  // stage m1: cosine sign/clamp, a*b, a^2, b^2
  logic signed [33:0] cx;
  logic [30:0] cmag_nxt;
  logic        v1_r, neg1_r;
  logic [30:0] cmag1_r;
  logic [31:0] ab1_r;
  logic [32:0] sq1_r;

  always_comb begin
    cx = crow[N].neg ? -crow[N].x : crow[N].x;
    if (cx > loc_pkg::CordicOne) cx = loc_pkg::CordicOne;
    if (cx < -loc_pkg::CordicOne) cx = -loc_pkg::CordicOne;
    cmag_nxt = cx[33] ? 31'(-cx) : 31'(cx);
  end

  always_ff @(posedge clk) begin
    v1_r    <= rst_n & crow[N].vld;
    neg1_r  <= cx[33];
    cmag1_r <= cmag_nxt;
    ab1_r   <= 32'(crow[N].a) * 32'(crow[N].b);
    sq1_r   <= 33'(32'(crow[N].a) * 32'(crow[N].a)) +
               33'(32'(crow[N].b) * 32'(crow[N].b));
  end

  // stage m2: ab * |cos| split into two partial products on the 16-bit halves of ab
  logic        v2_r, neg2_r;
  logic [32:0] sq2_r;
  logic [46:0] plo_r;
  logic [46:0] phi_r;

  always_ff @(posedge clk) begin
    v2_r   <= rst_n & v1_r;
    neg2_r <= neg1_r;
    sq2_r  <= sq1_r;
    plo_r  <= 47'(ab1_r[15:0]) * 47'(cmag1_r);
    phi_r  <= 47'(ab1_r[31:16]) * 47'(cmag1_r);
  end

  // stage m3: sum, round, radicand with clamp at zero
  logic [62:0] mag;
  logic [33:0] term;
  logic [34:0] radp;
  logic [34:0] rad;
  loc_pkg::sq_t srow [S+1];

  always_comb begin
    mag  = 63'(plo_r) + (63'(phi_r) << 16);
    term = 34'((mag + (63'd1 << 28)) >> 29);
    radp = 35'(sq2_r);
    if (neg2_r) rad = radp + 35'(term);
    else if (35'(term) > radp) rad = '0;
    else rad = radp - 35'(term);
  end

  loc_pkg::sq_t s0_r;
  always_ff @(posedge clk) begin
    s0_r.vld  <= rst_n & v2_r;
    s0_r.rem  <= 38'(rad);
    s0_r.root <= '0;
  end
  assign srow[0] = s0_r;

  // square root digit row, bit weight 2^36 down to 2^0
  for (genvar k = 0; k < S; k++) begin : g_sqrt
    loc_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .sh    (6'(36 - 2 * k)),
      .d_in  (srow[k]),
      .d_out (srow[k+1])
    );
  end

  // final rounding and output register
  logic        ov_r;
  logic [16:0] res_r;
  always_ff @(posedge clk) begin
    ov_r  <= rst_n & srow[S].vld;
    res_r <= 17'(srow[S].root + ((srow[S].rem > srow[S].root) ? 38'd1 : 38'd0));
  end

  assign out_valid         = ov_r;
  assign out_opposite_side = res_r;

  // every accepted item shows up as a result, and out_valid never rises without one
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ##40 ($past(acc, 40) == out_valid))
    else $error("result timing mismatch");

  // clamped cosine magnitude of a valid item does not exceed CordicOne
  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (cmag1_r <= 31'd1073741824))
    else $error("cosine out of range");

  // last root cell leaves a remainder below twice the root plus one
  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    srow[S].vld |-> (srow[S].rem <= (srow[S].root << 1)))
    else $error("root remainder too large");
endmodule

### verif/tb_law_of_cosines_side.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_law_of_cosines_side: self-checking bench for the law of cosines block
// drives side and angle items with random gaps, predicts each opposite side
// with a bit-exact fixed-point model and checks results in order
// ---------------------------------------------------------------------------
module tb_law_of_cosines_side;

  // predicted opposite sides, oldest first, and the error tally
  class side_board;
    logic [16:0] pending[$];
    int          errors;
    int          checked;

    // arithmetic shift right on a 64-bit signed value
    function automatic longint asr(longint v, int s);
      return v >>> s;
    endfunction

    // cosine in Q2.30 from an angle in Q8.8 degrees (already saturated)
    function automatic longint cos_q30(int unsigned ang);
      longint x, y, z, dx, dy;
      bit     flip;
      x = 64'sd652032874;
      y = 0;
      flip = 0;
      if (ang > loc_pkg::AngleRight) begin
        ang = loc_pkg::AngleMax - ang;
        flip = 1;
      end
      z = longint'(ang) * 256;
      for (int i = 0; i < loc_pkg::NumSteps; i++) begin
        dx = asr(y, i);
        dy = asr(x, i);
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - longint'(loc_pkg::AtanTab[i]);
        end else begin
          x = x + dx; y = y - dy; z = z + longint'(loc_pkg::AtanTab[i]);
        end
      end
      if (flip) x = -x;
      if (x > 64'sd1073741824) x = 64'sd1073741824;
      if (x < -64'sd1073741824) x = -64'sd1073741824;
      return x;
    endfunction

    // rounded integer square root by digit recurrence
    function automatic longint unsigned root_round(longint unsigned r);
      longint unsigned rem, root, bitv;
      rem = r; root = 0; bitv = 64'd1 << 36;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem = rem - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      if (rem > root) root++;
      return root;
    endfunction

    function automatic logic [16:0] opposite(logic [15:0] a, logic [15:0] b,
                                             logic [15:0] ang);
      longint          c, rad;
      longint unsigned ab, mag, term;
      int unsigned     angle_sat;
      angle_sat = 32'((ang > loc_pkg::AngleMax) ? loc_pkg::AngleMax : ang);
      c = cos_q30(angle_sat);
      ab = longint'(a) * longint'(b);
      mag = ab * longint'(c < 0 ? -c : c);
      term = (mag + (64'd1 << 28)) >> 29;
      rad = longint'(a) * a + longint'(b) * b;
      if (c < 0) rad = rad + longint'(term);
      else rad = rad - longint'(term);
      if (rad < 0) rad = 0;
      return 17'(root_round(rad));
    endfunction

    function void note_item(logic [15:0] a, logic [15:0] b, logic [15:0] ang);
      pending.push_back(opposite(a, b, ang));
    endfunction

    function void check_side(logic [16:0] got);
      logic [16:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result opposite_side=%0d", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: opposite_side mismatch expected %0d actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_first_side;
  logic [15:0] in_second_side;
  logic [15:0] in_included_angle;
  logic        out_valid;
  logic [16:0] out_opposite_side;

  side_board board;
  int        cycles;
  int        sent;
  int        sat_angles;
  int        obtuse_angles;

  law_of_cosines_side dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_side(in_first_side), .in_second_side(in_second_side),
    .in_included_angle(in_included_angle),
    .out_valid(out_valid), .out_opposite_side(out_opposite_side)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // results are sampled at the edge that ends their cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_side(out_opposite_side);
  end

  // watchdog: ~650 items with random gaps between them
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // present one item, hold it until accepted, then maybe idle
  task automatic send_item(logic [15:0] a, logic [15:0] b, logic [15:0] ang,
                           bit no_gap);
    int gap;
    start <= 1'b1;
    in_first_side <= a;
    in_second_side <= b;
    in_included_angle <= ang;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(a, b, ang);
    sent++;
    if (ang > loc_pkg::AngleMax) sat_angles++;
    else if (ang > loc_pkg::AngleRight) obtuse_angles++;
    if (!no_gap) begin
      // mostly back to back or short gaps, now and then a long one
      gap = ($urandom_range(0, 9) < 5) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
        start <= 1'b0;
        in_first_side <= 16'($urandom);
        in_second_side <= 16'($urandom);
        in_included_angle <= 16'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [15:0] pick_side();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 15));
      1:       return 16'($urandom_range(65500, 65535));
      2:       return 16'($urandom_range(0, 1023));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(46081, 65535)); // beyond 180, saturates
      1:       return 16'($urandom_range(23030, 23050)); // around the fold at 90
      2:       return 16'($urandom_range(0, 16));
      3:       return 16'($urandom_range(46060, 46080));
      default: return 16'($urandom_range(0, 46080));
    endcase
  endfunction

  initial begin
    logic [15:0] s;
    board = new();
    cycles = 0;
    sent = 0;
    sat_angles = 0;
    obtuse_angles = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_first_side <= '0;
    in_second_side <= '0;
    in_included_angle <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero and full-scale sides, angle extremes, fold, saturation
    send_item(16'd0, 16'd0, 16'd0, 0);
    send_item(16'hFFFF, 16'hFFFF, 16'd0, 0);      // degenerate, radicand near zero
    send_item(16'hFFFF, 16'hFFFF, loc_pkg::AngleMax, 0);   // largest result
    send_item(16'hFFFF, 16'd0, 16'd23040, 0);     // zero side, right angle
    send_item(16'd0, 16'hFFFF, 16'd12345, 1);
    send_item(16'd48, 16'd64, loc_pkg::AngleRight, 1);      // 3-4-5 triangle
    send_item(16'd48, 16'd64, loc_pkg::AngleRight + 16'd1, 0);
    send_item(16'd48, 16'd64, loc_pkg::AngleRight - 16'd1, 0);
    send_item(16'd100, 16'd100, 16'd15360, 0);     // equilateral
    send_item(16'd100, 16'd100, 16'd46081, 1);     // just above 180
    send_item(16'd100, 16'd100, 16'hFFFF, 1);      // all angle bits set
    send_item(16'h5555, 16'hAAAA, 16'h5555, 0);
    send_item(16'hAAAA, 16'h5555, 16'hAAAA, 0);
    send_item(16'd1, 16'd1, 16'd1, 0);
    send_item(16'd1, 16'hFFFF, loc_pkg::AngleMax - 16'd1, 0);
    send_item(16'h8000, 16'h8000, 16'd7680, 0);

    // random, with a back-to-back burst every so often
    for (int n = 0; n < 640; n++) begin
      s = pick_side();
      send_item(s, ($urandom_range(0, 7) == 0) ? s : pick_side(), pick_angle(),
                (n % 100) < 20);
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("sent %0d items, %0d results checked", sent, board.checked);
    $display("angles past 90 deg: %0d, past 180 deg (saturated): %0d",
             obtuse_angles, sat_angles);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
